// ===== design/dtu_pkg.sv =====
package dtu_pkg;

    // default lane count and fixed text geometry
    localparam int LANES_DEF  = 8;
    localparam int BYTE_LANES = 8;

    // digit classifier: (byte - bias) read as signed is below the limit for '0'..'9'
    localparam logic [7:0]        BYTE_BIAS   = 8'd176;
    localparam logic signed [7:0] DIGIT_LIMIT = -8'sd118;
    localparam logic [7:0]        ASCII_ZERO  = 8'h30;

    // longest number that can still fit in 64 bits
    localparam logic [7:0] MAX_DIGITS = 8'd20;

    // powers of ten up to 10^8 fit in 27 bits
    localparam int POW_W  = 27;
    localparam int TERM_W = POW_W + 4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ADD
    } state_t;

    typedef struct packed {
        logic mul_en;
        logic add_en;
        logic first;
        logic ended;
    } dtu_ctl_t;

    typedef struct packed {
        logic        emit;
        logic [63:0] value;
        logic [7:0]  digit_count;
        status_t     status;
    } dtu_res_t;

    function automatic logic [POW_W-1:0] pow10(input logic [4:0] e);
        logic [POW_W-1:0] p;
        case (e)
            5'd0:    p = POW_W'(1);
            5'd1:    p = POW_W'(10);
            5'd2:    p = POW_W'(100);
            5'd3:    p = POW_W'(1000);
            5'd4:    p = POW_W'(10000);
            5'd5:    p = POW_W'(100000);
            5'd6:    p = POW_W'(1000000);
            5'd7:    p = POW_W'(10000000);
            5'd8:    p = POW_W'(100000000);
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

// ===== design/decimal_text_to_uint64.sv =====
// decimal text to uint64: parses an unsigned decimal number from text that arrives eight bytes
// per transaction, earliest character in the lowest byte. a transaction with first set starts a
// new number; the leading run of ascii digits is folded into a 64-bit value across transactions
// and the first non-digit byte (or the end of valid_bytes) closes the number and yields one
// output transaction with value, digit_count (saturating at 255) and status (0 ok, 1 no digits,
// 2 overflow: more than 20 digits or above 2^64-1, value then reads 0). a chunk that is all
// digits yields nothing; close a buffer that ends on a chunk boundary with valid_bytes of 0.
// chunks without first while no number is open are dropped. timing: the next input transaction
// is taken only once the previous one has passed the multiply and add steps of the accumulator
// loop, and only while the output keeps up; the add step registers the result. the multiply
// step forms the two 32x27 partial products of value times 10^k; the add step does the 92-bit
// recombine, overflow check and state update, which overlaps with taking the next chunk.
module decimal_text_to_uint64 import dtu_pkg::*; #(
    parameter int LANES = LANES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        first,
    input  logic [63:0] chunk,
    input  logic [3:0]  valid_bytes,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] value,
    output logic [7:0]  digit_count,
    output logic [1:0]  status
);

    localparam int KW = $clog2(LANES + 1);

    state_t                      state_reg;
    state_t                      state_next;
    dtu_ctl_t                    ctl;
    dtu_res_t                    res;

    logic                        accept;
    logic                        out_free;
    logic [LANES-1:0]            lane_ok;
    logic [LANES-1:0]            lane_range;
    logic [LANES-1:0][7:0]       lane_byte;
    logic [LANES-1:0][TERM_W-1:0] terms;
    logic [KW-1:0]               k_next;
    logic [KW-1:0]               k_reg;
    logic                        first_reg;
    logic                        ended_reg;

    logic                        out_valid_reg;
    logic [63:0]                 value_reg;
    logic [7:0]                  count_reg;
    logic [1:0]                  status_reg;

    // one lane per byte position, positions past the chunk are never digits
    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        if (i < BYTE_LANES)
        begin : g_in
            assign lane_byte[i]  = chunk[8*i +: 8];
            assign lane_range[i] = (4'(i) < valid_bytes);
        end
        else
        begin : g_out
            assign lane_byte[i]  = 8'h00;
            assign lane_range[i] = 1'b0;
        end

        dtu_lane #(
            .LANES (LANES),
            .IDX   (i),
            .KW    (KW)
        ) u_lane (
            .clk      (clk),
            .byte_in  (lane_byte[i]),
            .in_range (lane_range[i]),
            .load     (accept),
            .k        (k_reg),
            .ok       (lane_ok[i]),
            .term     (terms[i])
        );
    end

    // length of the leading digit run
    always_comb
    begin
        k_next = KW'(LANES);
        for (int i = LANES - 1; i >= 0; i--)
        begin
            if (!lane_ok[i])
            begin
                k_next = KW'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            k_reg     <= k_next;
            first_reg <= first;
            ended_reg <= (k_next != KW'(LANES));
        end
    end

    // handshake and sequencing
    assign out_free = !out_valid_reg || !out_stall;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        ctl.mul_en = 1'b0;
        ctl.add_en = 1'b0;
        ctl.first  = first_reg;
        ctl.ended  = ended_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                ctl.mul_en = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                // commit only when the output register can take a result
                if (out_free)
                begin
                    ctl.add_en = 1'b1;
                    in_stall   = 1'b0;
                    state_next = in_valid ? S_MUL : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    dtu_merge #(
        .LANES (LANES),
        .KW    (KW)
    ) u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .k     (k_reg),
        .terms (terms),
        .res   (res)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.add_en && res.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.add_en && res.emit)
        begin
            value_reg  <= res.value;
            count_reg  <= res.digit_count;
            status_reg <= res.status;
        end
    end

    assign out_valid   = out_valid_reg;
    assign value       = value_reg;
    assign digit_count = count_reg;
    assign status      = status_reg;

endmodule

// ===== design/dtu_lane.sv =====
module dtu_lane import dtu_pkg::*; #(
    parameter int LANES = LANES_DEF,
    parameter int IDX   = 0,
    parameter int KW    = $clog2(LANES + 1)
) (
    input  logic              clk,
    input  logic [7:0]        byte_in,
    input  logic              in_range,
    input  logic              load,
    input  logic [KW-1:0]     k,
    output logic              ok,
    output logic [TERM_W-1:0] term
);

    localparam logic [4:0] IDX5 = 5'(IDX);

    logic [7:0]       biased;
    logic [3:0]       digit_reg;
    logic [POW_W-1:0] weight;

    // ascii digit test
    assign biased = byte_in - BYTE_BIAS;
    assign ok     = in_range && ($signed(biased) < DIGIT_LIMIT);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            digit_reg <= 4'(byte_in - ASCII_ZERO);
        end
    end

    // decimal weight of this lane within the leading run
    always_comb
    begin
        if (5'(k) > IDX5)
        begin
            weight = pow10(5'(k) - IDX5 - 5'd1);
        end
        else
        begin
            weight = '0;
        end
    end

    assign term = digit_reg * weight;

endmodule

// ===== design/dtu_merge.sv =====
module dtu_merge import dtu_pkg::*; #(
    parameter int LANES = LANES_DEF,
    parameter int KW    = $clog2(LANES + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dtu_ctl_t                    ctl,
    input  logic [KW-1:0]               k,
    input  logic [LANES-1:0][TERM_W-1:0] terms,
    output dtu_res_t                    res
);

    logic [63:0]       acc_reg;
    logic [7:0]        digits_reg;
    logic              active_reg;
    logic              too_large_reg;

    logic [58:0]       prod_lo_reg;
    logic [58:0]       prod_hi_reg;
    logic [POW_W-1:0]  cval_reg;

    logic [63:0]       acc_eff;
    logic [POW_W-1:0]  pw;
    logic [POW_W-1:0]  csum;

    logic              live;
    logic [7:0]        ds_base;
    logic [8:0]        ds_sum;
    logic [7:0]        ds_new;
    logic [91:0]       total;
    logic              tl_new;

    // multiply stage inputs
    assign acc_eff = ctl.first ? 64'd0 : acc_reg;
    assign pw      = pow10(5'(k));

    always_comb
    begin
        csum = '0;
        for (int i = 0; i < LANES; i++)
        begin
            csum = csum + POW_W'(terms[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_lo_reg <= acc_eff[31:0] * pw;
            prod_hi_reg <= acc_eff[63:32] * pw;
            cval_reg    <= csum;
        end
    end

    // add stage: recombine halves, check for overflow
    assign live    = ctl.first || active_reg;
    assign ds_base = ctl.first ? 8'd0 : digits_reg;
    assign ds_sum  = 9'(ds_base) + 9'(k);
    assign ds_new  = ds_sum[8] ? 8'hFF : ds_sum[7:0];
    assign total   = 92'({prod_hi_reg, 32'd0}) + 92'(prod_lo_reg) + 92'(cval_reg);
    assign tl_new  = (!ctl.first && too_large_reg) || (ds_new > MAX_DIGITS)
                     || (|total[91:64]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            digits_reg    <= '0;
            active_reg    <= 1'b0;
            too_large_reg <= 1'b0;
        end
        else if (ctl.add_en && live)
        begin
            acc_reg       <= total[63:0];
            digits_reg    <= ds_new;
            active_reg    <= !ctl.ended;
            too_large_reg <= tl_new;
        end
    end

    always_comb
    begin
        res.emit = live && ctl.ended;
        if (ds_new == 8'd0)
        begin
            res.value       = 64'd0;
            res.digit_count = 8'd0;
            res.status      = ST_INVALID;
        end
        else if (tl_new)
        begin
            res.value       = 64'd0;
            res.digit_count = ds_new;
            res.status      = ST_OVERFLOW;
        end
        else
        begin
            res.value       = total[63:0];
            res.digit_count = ds_new;
            res.status      = ST_OK;
        end
    end

endmodule

// ===== design/dtu_checker.sv =====
module dtu_checker import dtu_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] value,
    input logic [7:0]  digit_count,
    input logic [1:0]  status
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value) && $stable(digit_count)
        && $stable(status))
        else $error("stalled result changed");

    // the input is stalled after every chunk that is taken
    a_in_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken in back-to-back cycles");

    a_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_INVALID |-> value == 64'd0 && digit_count == 8'd0)
        else $error("invalid result carries data");

    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OVERFLOW |-> value == 64'd0 && digit_count != 8'd0)
        else $error("overflow result malformed");

    a_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_INVALID && status != ST_OVERFLOW |->
        status == ST_OK && digit_count != 8'd0 && digit_count <= MAX_DIGITS)
        else $error("ok result with bad digit count or status code");

endmodule

bind decimal_text_to_uint64 dtu_checker u_dtu_checker (.*);
